// File: design/dense_shortest_path_engine_defines.svh
// Assertion shorthands for the shortest-path engine checkers.
// Every property is sampled on clk and held off while rst_n is low.
`ifndef DENSE_SHORTEST_PATH_ENGINE_DEFINES_SVH
`define DENSE_SHORTEST_PATH_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define DSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsp port check failed");

// Next-cycle implication.
`define DSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsp port check failed");

`endif

// File: design/dsp_pkg.sv
`default_nettype none

package dsp_pkg;

    // Node storage
    localparam int MAX_NODES = 16;
    localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int MAT_DEPTH = 1 << (2 * NODE_W);

    // Field widths
    localparam int DIST_W   = 10;
    localparam int FNODE_W  = 4;
    localparam int SRC_W    = 4;
    localparam int NCOUNT_W = 5;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [DIST_W-1:0] NO_LINK   = DIST_W'(999);
    localparam logic [DIST_W-1:0] ZERO_DIST = '0;

    // Request codes
    localparam logic REQ_SET     = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [FNODE_W-1:0] node_a;
        logic [FNODE_W-1:0] node_b;
        logic [DIST_W-1:0]  cost;
    } dsp_in_t;

    typedef struct packed {
        logic [FNODE_W-1:0] node_index;
        logic [DIST_W-1:0]  distance;
        logic               last;
    } dsp_out_t;

endpackage

`default_nettype wire

// File: design/dense_shortest_path_engine.sv
`default_nettype none

// Dense shortest-path engine. The block keeps a symmetric link-cost matrix in a
// synchronous RAM and answers two kinds of input transfer. A set-cost transfer
// (req_type 0) stores min(cost, 999) at (node_a, node_b) and (node_b, node_a)
// and gives no result. A compute transfer (req_type 1) runs a dense Dijkstra
// search from source_node over the first node_count nodes (0 reads as 1,
// anything above the node limit as the limit) and then streams one result
// transfer per node in index order, last set on the final one; 999 means
// unreachable. With n active nodes a compute first seeds the distance RAM and
// then runs n search passes: the cost-matrix read port delivers one entry per
// cycle and each pass of n reads closes with a write-back of the distance RAM.
// The next minimum is tracked while a pass relaxes, so no separate selection
// scan is needed. A new transfer is taken once the final result has been
// loaded into the output register, even if it still waits there. Matrix
// entries that were never written must not be reached by a search.
// Configuration registers sit at byte 0 (source_node) and byte 4
// (node_count) and may be written only while the block is idle.

module dense_shortest_path_engine
    import dsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire dsp_in_t            in_data,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dsp_out_t                out_data,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_INIT,
        S_RELAX,
        S_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Storage: cost matrix addressed {row, column}, distance per node.
    // Both are single write, single read, with a registered read.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] mat_mem  [MAT_DEPTH];
    logic [DIST_W-1:0] dist_mem [MAX_NODES];
    logic [DIST_W-1:0] mat_q_reg;
    logic [DIST_W-1:0] dist_q_reg;

    // Control and datapath registers
    state_t                state_reg,      state_next;
    logic [SRC_W-1:0]      src_reg,        src_next;
    logic [NCOUNT_W-1:0]   ncount_reg,     ncount_next;
    logic [CNT_W-1:0]      n_reg,          n_next;
    logic [NODE_W-1:0]     set_a_reg,      set_a_next;
    logic [NODE_W-1:0]     set_b_reg,      set_b_next;
    logic [DIST_W-1:0]     set_cost_reg,   set_cost_next;
    logic                  set_ok_reg,     set_ok_next;
    logic [CNT_W-1:0]      step_reg,       step_next;
    logic [CNT_W-1:0]      pass_reg,       pass_next;
    logic [NODE_W-1:0]     pick_reg,       pick_next;
    logic [DIST_W-1:0]     best_reg,       best_next;
    logic [MAX_NODES-1:0]  visited_reg,    visited_next;
    logic [DIST_W:0]       cand_best_reg,  cand_best_next;
    logic [NODE_W-1:0]     cand_pick_reg,  cand_pick_next;
    logic                  wb_valid_reg,   wb_valid_next;
    logic [NODE_W-1:0]     wb_idx_reg,     wb_idx_next;
    logic                  rd_pend_reg,    rd_pend_next;
    logic [NODE_W-1:0]     rd_idx_reg,     rd_idx_next;
    logic                  rd_last_reg,    rd_last_next;
    logic                  out_valid_reg,  out_valid_next;
    dsp_out_t              out_reg,        out_next;

    // Memory port controls
    logic                  mat_we;
    logic [2*NODE_W-1:0]   mat_waddr;
    logic [DIST_W-1:0]     mat_wdata;
    logic                  mat_re;
    logic [2*NODE_W-1:0]   mat_raddr;
    logic                  dist_we;
    logic [NODE_W-1:0]     dist_waddr;
    logic [DIST_W-1:0]     dist_wdata;
    logic                  dist_re;
    logic [NODE_W-1:0]     dist_raddr;

    // Helpers
    logic                  in_take;
    logic                  cfg_write;
    logic                  cfg_sel;
    logic [CNT_W-1:0]      n_act;
    logic [DIST_W-1:0]     cost_sat;
    logic                  ab_ok;
    logic [NODE_W-1:0]     step_idx;
    logic                  step_more;
    logic                  step_final;
    logic [DIST_W:0]       via;
    logic                  via_less;
    logic [DIST_W-1:0]     new_dist;
    logic                  cand_take;
    logic [DIST_W:0]       cand_best_upd;
    logic [NODE_W-1:0]     cand_pick_upd;
    logic                  pass_end;
    logic                  src_in_run;
    logic                  out_free;
    logic                  out_issue;
    logic                  out_load;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[2];

    always_comb
    begin
        unique case (cfg_sel)
            REG_SOURCE: prdata = DATA_W'(src_reg);
            REG_COUNT:  prdata = DATA_W'(ncount_reg);
            default:    prdata = '0;
        endcase
    end

    // Active node count: zero reads as one, above the limit saturates.
    always_comb
    begin
        if (ncount_reg == '0)
            n_act = CNT_W'(1);
        else if (32'(ncount_reg) > 32'(MAX_NODES))
            n_act = CNT_W'(MAX_NODES);
        else
            n_act = CNT_W'(ncount_reg);
    end

    assign cost_sat   = (in_data.cost > NO_LINK) ? NO_LINK : in_data.cost;
    assign ab_ok      = (32'(in_data.node_a) < 32'(MAX_NODES)) &&
                        (32'(in_data.node_b) < 32'(MAX_NODES));
    assign step_idx   = step_reg[NODE_W-1:0];
    assign step_more  = (step_reg < n_reg);
    assign step_final = (step_reg == n_reg - CNT_W'(1));
    assign src_in_run = (32'(src_reg) < 32'(n_reg));

    // Relaxation of the node whose reads came back this cycle
    assign via      = {1'b0, best_reg} + {1'b0, mat_q_reg};
    assign via_less = (via < {1'b0, dist_q_reg});
    assign new_dist = via_less ? via[DIST_W-1:0] : dist_q_reg;

    // Running minimum over unvisited nodes, lowest index wins on ties
    assign cand_take     = wb_valid_reg && !visited_reg[wb_idx_reg] &&
                           ({1'b0, new_dist} < cand_best_reg);
    assign cand_best_upd = cand_take ? {1'b0, new_dist} : cand_best_reg;
    assign cand_pick_upd = cand_take ? wb_idx_reg : cand_pick_reg;

    assign pass_end = (state_reg == S_RELAX) && !step_more && wb_valid_reg;

    // Result streaming: the RAM read register holds while the output waits
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = rd_pend_reg && out_free;
    assign out_issue = (state_reg == S_OUT) && step_more && (!rd_pend_reg || out_load);

    // Memory port steering
    always_comb
    begin
        mat_we     = 1'b0;
        mat_waddr  = {set_b_reg, set_a_reg};
        mat_wdata  = set_cost_reg;
        if (in_take && (in_data.req_type == REQ_SET) && ab_ok)
        begin
            mat_we    = 1'b1;
            mat_waddr = {NODE_W'(in_data.node_a), NODE_W'(in_data.node_b)};
            mat_wdata = cost_sat;
        end
        else if ((state_reg == S_SET) && set_ok_reg)
        begin
            mat_we = 1'b1;
        end

        mat_re    = (state_reg == S_RELAX) && step_more;
        mat_raddr = {step_idx, pick_reg};

        dist_we    = 1'b0;
        dist_waddr = step_idx;
        dist_wdata = NO_LINK;
        if (state_reg == S_INIT)
        begin
            dist_we    = 1'b1;
            dist_wdata = (32'(step_reg) == 32'(src_reg)) ? ZERO_DIST : NO_LINK;
        end
        else if ((state_reg == S_RELAX) && wb_valid_reg)
        begin
            dist_we    = 1'b1;
            dist_waddr = wb_idx_reg;
            dist_wdata = new_dist;
        end

        dist_re    = mat_re || out_issue;
        dist_raddr = step_idx;
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        ncount_next    = ncount_reg;
        n_next         = n_reg;
        set_a_next     = set_a_reg;
        set_b_next     = set_b_reg;
        set_cost_next  = set_cost_reg;
        set_ok_next    = set_ok_reg;
        step_next      = step_reg;
        pass_next      = pass_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        visited_next   = visited_reg;
        cand_best_next = cand_best_reg;
        cand_pick_next = cand_pick_reg;
        wb_valid_next  = 1'b0;
        wb_idx_next    = wb_idx_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        rd_last_next   = rd_last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_SOURCE: src_next    = pwdata[SRC_W-1:0];
                REG_COUNT:  ncount_next = pwdata[NCOUNT_W-1:0];
                default:    src_next    = src_reg;
            endcase
        end

        // Output register: load a fresh result or drop the one taken
        if (out_load)
        begin
            out_valid_next      = 1'b1;
            out_next.node_index = FNODE_W'(rd_idx_reg);
            out_next.distance   = dist_q_reg;
            out_next.last       = rd_last_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (in_data.req_type == REQ_SET)
                    begin
                        set_a_next    = NODE_W'(in_data.node_a);
                        set_b_next    = NODE_W'(in_data.node_b);
                        set_cost_next = cost_sat;
                        set_ok_next   = ab_ok;
                        state_next    = S_SET;
                    end
                    else
                    begin
                        n_next       = n_act;
                        step_next    = '0;
                        pass_next    = '0;
                        visited_next = '0;
                        state_next   = S_INIT;
                    end
                end
            end

            S_SET:
            begin
                state_next = S_IDLE;
            end

            S_INIT:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_final)
                begin
                    // First pick: the source, or node 0 when every node is at 999
                    pick_next                = src_in_run ? NODE_W'(src_reg) : '0;
                    best_next                = src_in_run ? ZERO_DIST : NO_LINK;
                    visited_next[pick_next]  = 1'b1;
                    cand_best_next           = {1'b0, NO_LINK} + (DIST_W+1)'(1);
                    cand_pick_next           = '0;
                    step_next                = '0;
                    state_next               = S_RELAX;
                end
            end

            S_RELAX:
            begin
                cand_best_next = cand_best_upd;
                cand_pick_next = cand_pick_upd;
                if (step_more)
                begin
                    wb_valid_next = 1'b1;
                    wb_idx_next   = step_idx;
                    step_next     = step_reg + CNT_W'(1);
                end
                if (pass_end)
                begin
                    pass_next = pass_reg + CNT_W'(1);
                    step_next = '0;
                    if (pass_reg + CNT_W'(1) == n_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pick_next               = cand_pick_upd;
                        best_next               = cand_best_upd[DIST_W-1:0];
                        visited_next[pick_next] = 1'b1;
                        cand_best_next          = {1'b0, NO_LINK} + (DIST_W+1)'(1);
                        cand_pick_next          = '0;
                    end
                end
            end

            S_OUT:
            begin
                if (out_issue)
                begin
                    rd_idx_next  = step_idx;
                    rd_last_next = step_final;
                    step_next    = step_reg + CNT_W'(1);
                end
                // Leave once the final result sits in the output register
                if (out_load && rd_last_reg)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_issue)
            rd_pend_next = 1'b1;
        else if (out_load)
            rd_pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_reg       <= '0;
            ncount_reg    <= NCOUNT_W'(16);
            n_reg         <= CNT_W'(1);
            set_a_reg     <= '0;
            set_b_reg     <= '0;
            set_cost_reg  <= '0;
            set_ok_reg    <= 1'b0;
            step_reg      <= '0;
            pass_reg      <= '0;
            pick_reg      <= '0;
            best_reg      <= '0;
            visited_reg   <= '0;
            cand_best_reg <= '0;
            cand_pick_reg <= '0;
            wb_valid_reg  <= 1'b0;
            wb_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            ncount_reg    <= ncount_next;
            n_reg         <= n_next;
            set_a_reg     <= set_a_next;
            set_b_reg     <= set_b_next;
            set_cost_reg  <= set_cost_next;
            set_ok_reg    <= set_ok_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            pick_reg      <= pick_next;
            best_reg      <= best_next;
            visited_reg   <= visited_next;
            cand_best_reg <= cand_best_next;
            cand_pick_reg <= cand_pick_next;
            wb_valid_reg  <= wb_valid_next;
            wb_idx_reg    <= wb_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // RAMs: no reset, contents defined only once written
    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_waddr] <= mat_wdata;
        if (mat_re)
            mat_q_reg <= mat_mem[mat_raddr];
        if (dist_we)
            dist_mem[dist_waddr] <= dist_wdata;
        if (dist_re)
            dist_q_reg <= dist_mem[dist_raddr];
    end

endmodule

`default_nettype wire

// File: design/dsp_port_checker.sv
`default_nettype none

`include "dense_shortest_path_engine_defines.svh"

module dsp_port_checker
    import dsp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire dsp_in_t            in_data,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire dsp_out_t           out_data
);

    // Hold a stalled result unchanged
    `DSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // Reported distances never exceed the no-link value
    `DSP_ASSERT_NOW(a_dist_range, out_valid, out_data.distance <= NO_LINK)

    // A compute transfer keeps the request side stalled while it runs
    `DSP_ASSERT_NEXT(a_compute_busy, in_valid && !in_stall && in_data.req_type == REQ_COMPUTE,
                     in_stall)

    // A result run that has not ended still blocks new requests
    `DSP_ASSERT_NOW(a_run_busy, out_valid && !out_stall && !out_data.last, in_stall)

endmodule

bind dense_shortest_path_engine dsp_port_checker u_dsp_port_checker (.*);

`default_nettype wire
